@@ src/omni_wheel_mixer_with_watchdog_core_assert.svh @@
// Assertion macros shared by the omni wheel mixer RTL.
`ifndef OMNI_WHEEL_MIXER_WITH_WATCHDOG_CORE_ASSERT_SVH
`define OMNI_WHEEL_MIXER_WITH_WATCHDOG_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define OWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("omni wheel mixer check failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define OWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("omni wheel mixer check failed");

`endif

@@ src/owm_pkg.sv @@
// Types and constants shared by the omni wheel mixer modules.
`default_nettype none
package owm_pkg;

    localparam int SPEED_W  = 16;
    localparam int ANGLE_W  = 8;
    localparam int PWM_W    = 8;
    localparam int TICK_W   = 16;
    localparam int DB_W     = 12;
    localparam int REQ_W    = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG = 1'd1;

    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FWD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STRAFE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TURN   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PETAL  = 3'd4;

    localparam logic [DB_W-1:0]   DEADBAND_INIT = 12'd41;
    localparam logic [TICK_W-1:0] WATCHDOG_INIT = 16'd7000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    localparam logic [ANGLE_W-1:0] ANGLE_CLOSED = 8'd94;
    localparam logic [ANGLE_W-1:0] ANGLE_OPEN   = 8'd131;
    localparam logic [ANGLE_W-1:0] ANGLE_INIT   = 8'd103;
    localparam int ANGLE_SPAN = 37;

    // Wheel coefficients in Q.16.
    localparam int COEF_W     = 25;
    localparam int COEF_SHIFT = 16;
    localparam logic signed [COEF_W-1:0] COEF_STRAFE = 25'sd4681143;
    localparam logic signed [COEF_W-1:0] COEF_FWD    = 25'sd8107977;
    localparam logic signed [COEF_W-1:0] COEF_TURN   = -25'sd9362286;
    localparam logic signed [COEF_W-1:0] COEF_BACK   = -25'sd9362286;

    localparam int PROD_W = SPEED_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic signed [SPEED_W-1:0] fwd;
        logic signed [SPEED_W-1:0] strafe;
        logic signed [SPEED_W-1:0] turn;
        logic [ANGLE_W-1:0]        angle;
        logic                      timed_out;
    } owm_job_t;

    typedef struct packed {
        logic [PWM_W-1:0] fwd;
        logic [PWM_W-1:0] rev;
    } owm_wheel_t;

endpackage
`default_nettype wire

@@ src/owm_cmd_if.sv @@
// Setpoint channel: valid/ready handshake with request type and setpoint.
`default_nettype none
interface owm_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [15:0] setpoint;

    modport source (output valid, output req_type, output setpoint, input ready);
    modport sink (input valid, input req_type, input setpoint, output ready);
endinterface
`default_nettype wire

@@ src/owm_drv_if.sv @@
// Drive result channel: valid/ready handshake with wheel PWM and servo angle.
`default_nettype none
interface owm_drv_if;
    logic       valid;
    logic       ready;
    logic [7:0] right_fwd_pwm;
    logic [7:0] right_rev_pwm;
    logic [7:0] back_fwd_pwm;
    logic [7:0] back_rev_pwm;
    logic [7:0] left_fwd_pwm;
    logic [7:0] left_rev_pwm;
    logic [7:0] servo_angle;
    logic       timed_out;

    modport source (
        output valid, output right_fwd_pwm, output right_rev_pwm,
        output back_fwd_pwm, output back_rev_pwm, output left_fwd_pwm,
        output left_rev_pwm, output servo_angle, output timed_out, input ready
    );
    modport sink (
        input valid, input right_fwd_pwm, input right_rev_pwm,
        input back_fwd_pwm, input back_rev_pwm, input left_fwd_pwm,
        input left_rev_pwm, input servo_angle, input timed_out, output ready
    );
endinterface
`default_nettype wire

@@ src/owm_front.sv @@
// Front end: accepts setpoint beats, keeps speeds, servo angle and watchdog state.
`default_nettype none
`include "omni_wheel_mixer_with_watchdog_core_assert.svh"
module owm_front
    import owm_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    owm_cmd_if.sink                    cmd,
    input  wire logic                  q_full,
    output logic                       push,
    output owm_job_t                   push_job
);

    localparam int AW = FRAC_BITS + 18;
    localparam logic signed [AW-1:0] ONE_Q = AW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] NEG_ONE_Q = -ONE_Q;

    logic [DB_W-1:0]           deadband_reg, deadband_next;
    logic [TICK_W-1:0]         wd_limit_reg, wd_limit_next;
    logic signed [SPEED_W-1:0] fwd_reg, fwd_next;
    logic signed [SPEED_W-1:0] strafe_reg, strafe_next;
    logic signed [SPEED_W-1:0] turn_reg, turn_next;
    logic [ANGLE_W-1:0]        servo_angle_reg, servo_angle_next;
    logic [TICK_W-1:0]         idle_ticks_reg, idle_ticks_next;

    logic                      accept;
    logic                      is_tick;
    logic                      is_cmd;
    logic [TICK_W-1:0]         ticks_inc;
    logic                      wd_fire;
    logic signed [AW-1:0]      p_ext;
    logic signed [AW-1:0]      p_clamp;
    logic [AW-1:0]             p_off;
    logic [AW+5:0]             p_scaled;
    logic [ANGLE_W-1:0]        petal_angle;

    function automatic logic signed [SPEED_W-1:0] deadband_cut(
        input logic signed [SPEED_W-1:0] v,
        input logic [DB_W-1:0]           db
    );
        logic [SPEED_W:0] mag;
        mag = v[SPEED_W-1] ? -{v[SPEED_W-1], v} : {1'b0, v};
        return (mag < (SPEED_W+1)'(db)) ? '0 : v;
    endfunction

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign is_tick   = (cmd.req_type == REQ_TICK);
    assign is_cmd    = (cmd.req_type inside {[REQ_FWD:REQ_PETAL]});

    assign ticks_inc = (idle_ticks_reg == TICK_MAX) ? idle_ticks_reg : idle_ticks_reg + 1'b1;
    assign wd_fire   = (ticks_inc > wd_limit_reg);

    // Petal setpoint is clamped to [-1, 1] and scaled onto the 37 degree span.
    always_comb
    begin
        p_ext = {{(AW-SPEED_W){cmd.setpoint[SPEED_W-1]}}, cmd.setpoint};
        if (p_ext > ONE_Q)
            p_clamp = ONE_Q;
        else if (p_ext < NEG_ONE_Q)
            p_clamp = NEG_ONE_Q;
        else
            p_clamp = p_ext;
        p_off       = p_clamp + ONE_Q;
        p_scaled    = (AW+6)'(p_off) * (AW+6)'(ANGLE_SPAN);
        petal_angle = ANGLE_CLOSED + ANGLE_W'(p_scaled >> (FRAC_BITS + 1));
    end

    always_comb
    begin
        deadband_next    = deadband_reg;
        wd_limit_next    = wd_limit_reg;
        fwd_next         = fwd_reg;
        strafe_next      = strafe_reg;
        turn_next        = turn_reg;
        servo_angle_next = servo_angle_reg;
        idle_ticks_next  = idle_ticks_reg;
        push             = 1'b0;
        push_job         = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEADBAND: deadband_next = cfg_data[DB_W-1:0];
                CFG_WATCHDOG: wd_limit_next = cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end

        if (accept)
        begin
            case (cmd.req_type)
                REQ_TICK:
                begin
                    if (wd_fire)
                    begin
                        fwd_next           = '0;
                        strafe_next        = '0;
                        turn_next          = '0;
                        idle_ticks_next    = '0;
                        push               = 1'b1;
                        push_job.angle     = servo_angle_reg;
                        push_job.timed_out = 1'b1;
                    end
                    else
                    begin
                        idle_ticks_next = ticks_inc;
                    end
                end
                REQ_FWD, REQ_STRAFE, REQ_TURN, REQ_PETAL:
                begin
                    if (cmd.req_type == REQ_FWD)
                        fwd_next = cmd.setpoint;
                    if (cmd.req_type == REQ_STRAFE)
                        strafe_next = cmd.setpoint;
                    if (cmd.req_type == REQ_TURN)
                        turn_next = cmd.setpoint;
                    if (cmd.req_type == REQ_PETAL)
                        servo_angle_next = petal_angle;
                    // The deadband is applied to all three speeds on every command.
                    fwd_next           = deadband_cut(fwd_next, deadband_reg);
                    strafe_next        = deadband_cut(strafe_next, deadband_reg);
                    turn_next          = deadband_cut(turn_next, deadband_reg);
                    idle_ticks_next    = '0;
                    push               = 1'b1;
                    push_job.fwd       = fwd_next;
                    push_job.strafe    = strafe_next;
                    push_job.turn      = turn_next;
                    push_job.angle     = servo_angle_next;
                    push_job.timed_out = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= DEADBAND_INIT;
            wd_limit_reg    <= WATCHDOG_INIT;
            fwd_reg         <= '0;
            strafe_reg      <= '0;
            turn_reg        <= '0;
            servo_angle_reg <= ANGLE_INIT;
            idle_ticks_reg  <= '0;
        end
        else
        begin
            deadband_reg    <= deadband_next;
            wd_limit_reg    <= wd_limit_next;
            fwd_reg         <= fwd_next;
            strafe_reg      <= strafe_next;
            turn_reg        <= turn_next;
            servo_angle_reg <= servo_angle_next;
            idle_ticks_reg  <= idle_ticks_next;
        end
    end

    `OWM_ASSERT_NEXT(a_cmd_clears_idle, accept && is_cmd, idle_ticks_reg == '0)
    `OWM_ASSERT_NOW(a_angle_range, 1'b1, servo_angle_reg >= ANGLE_CLOSED && servo_angle_reg <= ANGLE_OPEN)
    `OWM_ASSERT_NOW(a_push_has_room, push, !q_full)
    `OWM_ASSERT_NOW(a_wd_fire_pushes, accept && is_tick && wd_fire, push && push_job.timed_out)

endmodule
`default_nettype wire

@@ src/owm_queue.sv @@
// Short job queue between the front end and the mixing back end.
`default_nettype none
`include "omni_wheel_mixer_with_watchdog_core_assert.svh"
module owm_queue
    import owm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire owm_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          nonempty,
    output owm_job_t      pop_job
);

    owm_job_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_job  = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `OWM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `OWM_ASSERT_NEXT(a_push_only_grows, push && !full && !pop, count_reg == $past(count_reg) + 1'b1)
    `OWM_ASSERT_NOW(a_ptr_gap, 1'b1, QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))

endmodule
`default_nettype wire

@@ src/owm_back.sv @@
// Back end: three-stage wheel mixing, saturation and sign split with an output register.
`default_nettype none
module owm_back
    import owm_pkg::*;
#(
    parameter int FRAC_BITS = 12,
    parameter int PWM_LIMIT = 255
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    input  wire owm_job_t job,
    output logic          pop,
    owm_drv_if.source     drv
);

    localparam int SHIFT = FRAC_BITS + COEF_SHIFT;
    localparam logic [SUM_W-1:0] LIMIT_EXT = SUM_W'(PWM_LIMIT);

    typedef struct packed {
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] b;
        logic signed [PROD_W-1:0] f;
        logic signed [PROD_W-1:0] t;
        logic [ANGLE_W-1:0]       angle;
        logic                     timed_out;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] right;
        logic signed [SUM_W-1:0] back;
        logic signed [SUM_W-1:0] left;
        logic [ANGLE_W-1:0]      angle;
        logic                    timed_out;
    } sum_t;

    typedef struct packed {
        owm_wheel_t         right;
        owm_wheel_t         back;
        owm_wheel_t         left;
        logic [ANGLE_W-1:0] angle;
        logic               timed_out;
    } result_t;

    logic    v1_reg, v1_next;
    logic    v2_reg, v2_next;
    logic    v3_reg, v3_next;
    prod_t   prod_reg, prod_next;
    sum_t    sum_reg, sum_next;
    result_t res_reg, res_next;
    logic    adv1;
    logic    adv2;
    logic    adv3;

    function automatic owm_wheel_t wheel_split(input logic signed [SUM_W-1:0] sum);
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] lvl;
        owm_wheel_t       w;
        neg = sum[SUM_W-1];
        mag = neg ? -sum : sum;
        lvl = mag >> SHIFT;
        if (lvl > LIMIT_EXT)
            lvl = LIMIT_EXT;
        w.fwd = neg ? '0 : lvl[PWM_W-1:0];
        w.rev = neg ? lvl[PWM_W-1:0] : '0;
        return w;
    endfunction

    // A stage moves on when it is empty or the stage after it moves on.
    assign adv3 = !v3_reg || drv.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign pop  = job_valid && adv1;

    always_comb
    begin
        v1_next   = adv1 ? job_valid : v1_reg;
        v2_next   = adv2 ? v1_reg : v2_reg;
        v3_next   = adv3 ? v2_reg : v3_reg;
        prod_next = prod_reg;
        sum_next  = sum_reg;
        res_next  = res_reg;

        if (pop)
        begin
            prod_next.s         = PROD_W'(COEF_STRAFE) * PROD_W'(job.strafe);
            prod_next.b         = PROD_W'(COEF_BACK) * PROD_W'(job.strafe);
            prod_next.f         = PROD_W'(COEF_FWD) * PROD_W'(job.fwd);
            prod_next.t         = PROD_W'(COEF_TURN) * PROD_W'(job.turn);
            prod_next.angle     = job.angle;
            prod_next.timed_out = job.timed_out;
        end

        if (adv2 && v1_reg)
        begin
            sum_next.right     = SUM_W'(prod_reg.s) + SUM_W'(prod_reg.f) + SUM_W'(prod_reg.t);
            sum_next.back      = SUM_W'(prod_reg.b) + SUM_W'(prod_reg.t);
            sum_next.left      = SUM_W'(prod_reg.s) - SUM_W'(prod_reg.f) + SUM_W'(prod_reg.t);
            sum_next.angle     = prod_reg.angle;
            sum_next.timed_out = prod_reg.timed_out;
        end

        if (adv3 && v2_reg)
        begin
            res_next.right     = wheel_split(sum_reg.right);
            res_next.back      = wheel_split(sum_reg.back);
            res_next.left      = wheel_split(sum_reg.left);
            res_next.angle     = sum_reg.angle;
            res_next.timed_out = sum_reg.timed_out;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign drv.valid         = v3_reg;
    assign drv.right_fwd_pwm = res_reg.right.fwd;
    assign drv.right_rev_pwm = res_reg.right.rev;
    assign drv.back_fwd_pwm  = res_reg.back.fwd;
    assign drv.back_rev_pwm  = res_reg.back.rev;
    assign drv.left_fwd_pwm  = res_reg.left.fwd;
    assign drv.left_rev_pwm  = res_reg.left.rev;
    assign drv.servo_angle   = res_reg.angle;
    assign drv.timed_out     = res_reg.timed_out;

endmodule
`default_nettype wire

@@ src/omni_wheel_mixer_with_watchdog_core.sv @@
// Top level of the three-wheel omni mixer with petal servo and command watchdog.
// A command beat, or a tick that trips the watchdog, yields one result beat through the queue.
// One beat per cycle is accepted while the 4-entry job queue has room; mixing takes 3 stages.
// Ticks that do not trip the watchdog update state only and produce no result beat.
// Reset: deadband 41, watchdog limit 7000, speeds and idle count zero, servo at 103 degrees.
`default_nettype none
module omni_wheel_mixer_with_watchdog_core
    import owm_pkg::*;
#(
    parameter int FRAC_BITS = 12,
    parameter int PWM_LIMIT = 255
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    owm_cmd_if.sink                    cmd,
    owm_drv_if.source                  drv
);

    logic     q_full;
    logic     push;
    owm_job_t push_job;
    logic     pop;
    logic     q_nonempty;
    owm_job_t q_job;

    owm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    owm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .nonempty (q_nonempty),
        .pop_job  (q_job)
    );

    owm_back #(
        .FRAC_BITS (FRAC_BITS),
        .PWM_LIMIT (PWM_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_nonempty),
        .job       (q_job),
        .pop       (pop),
        .drv       (drv)
    );

endmodule
`default_nettype wire

@@ tb/tb_omni_wheel_mixer_with_watchdog_core.sv @@
// Self-checking testbench for the omni wheel mixer: directed table, random phases, scoreboard.
module tb_omni_wheel_mixer_with_watchdog_core
    import owm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WHEEL_SHIFT = 28;
    localparam longint WHEEL_CAP   = 64'sd255 <<< WHEEL_SHIFT;
    localparam longint K_STRAFE    = 64'sd4681143;
    localparam longint K_FWD       = 64'sd8107977;
    localparam longint K_TURN      = -64'sd9362286;
    localparam longint K_BACK      = -64'sd9362286;
    localparam int     Q_ONE       = 4096;
    localparam int     ITEMS_PER_PHASE = 155;
    localparam int     NUM_PHASES  = 6;
    localparam int     DIRECTED_WD_LIMIT = 40;

    // Request codes the block leaves unused.
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int PH_DEADBAND[NUM_PHASES] = '{0, 4095, 41, 1234, 7, 300};
    localparam int PH_LIMIT[NUM_PHASES]    = '{0, 65535, 5, 12, 1, 30};
    localparam int PH_GAP[NUM_PHASES]      = '{25, 0, 25, 0, 30, 15};
    localparam int PH_STALL[NUM_PHASES]    = '{25, 0, 0, 30, 30, 15};

    typedef struct packed {
        logic [7:0] right_fwd;
        logic [7:0] right_rev;
        logic [7:0] back_fwd;
        logic [7:0] back_rev;
        logic [7:0] left_fwd;
        logic [7:0] left_rev;
        logic [7:0] servo;
        logic       timed_out;
    } drive_t;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic signed [SPEED_W-1:0] sp;
        int                        reps;
        bit                        typed;
        drive_t                    want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    owm_cmd_if cmd();
    owm_drv_if drv();

    omni_wheel_mixer_with_watchdog_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .drv       (drv)
    );

    always #6 clk = ~clk;

    // Mirror of the block's state and registers.
    logic signed [SPEED_W-1:0] m_fwd, m_strafe, m_turn;
    logic [ANGLE_W-1:0]        m_angle;
    logic [TICK_W-1:0]         m_idle;
    logic [DB_W-1:0]           m_deadband;
    logic [TICK_W-1:0]         m_wd_limit;

    drive_t expected_drive[$];
    stim_row_t plan[$];
    int fails = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    function automatic logic signed [SPEED_W-1:0] squelch(input logic signed [SPEED_W-1:0] v);
        int mag;
        mag = (v < 0) ? -int'(v) : int'(v);
        return (mag < int'(m_deadband)) ? '0 : v;
    endfunction

    function automatic void wheel_split(input longint sum, output logic [7:0] fwd,
                                        output logic [7:0] rev);
        longint mag;
        mag = (sum < 0) ? -sum : sum;
        if (mag > WHEEL_CAP)
            mag = WHEEL_CAP;
        mag = mag >>> WHEEL_SHIFT;
        fwd = (sum < 0) ? 8'd0 : 8'(mag);
        rev = (sum < 0) ? 8'(mag) : 8'd0;
    endfunction

    function automatic drive_t drive_mix(input bit zero_drive, input bit watchdog);
        longint s, f, w, right, back, left;
        drive_t d;
        s = longint'(m_strafe);
        f = longint'(m_fwd);
        w = longint'(m_turn);
        right = 0;
        back = 0;
        left = 0;
        if (!zero_drive)
        begin
            right = K_STRAFE * s + K_FWD * f + K_TURN * w;
            back  = K_BACK * s + K_TURN * w;
            left  = K_STRAFE * s - K_FWD * f + K_TURN * w;
        end
        wheel_split(right, d.right_fwd, d.right_rev);
        wheel_split(back, d.back_fwd, d.back_rev);
        wheel_split(left, d.left_fwd, d.left_rev);
        d.servo = m_angle;
        d.timed_out = watchdog;
        return d;
    endfunction

    function automatic logic [ANGLE_W-1:0] petal_to_angle(input logic signed [SPEED_W-1:0] p);
        int q;
        q = p;
        if (q > Q_ONE)
            q = Q_ONE;
        if (q < -Q_ONE)
            q = -Q_ONE;
        return 8'(94 + ((q + Q_ONE) * 37) / (2 * Q_ONE));
    endfunction

    // Advances the mirrored state by one accepted beat; returns 1 when a drive beat follows.
    function automatic bit mixer_step(input logic [REQ_W-1:0] req,
                                      input logic signed [SPEED_W-1:0] sp, output drive_t res);
        res = '0;
        if (req == REQ_TICK)
        begin
            if (m_idle != TICK_MAX)
                m_idle = m_idle + 1'b1;
            if (m_idle <= m_wd_limit)
                return 1'b0;
            m_fwd = '0;
            m_strafe = '0;
            m_turn = '0;
            m_idle = '0;
            res = drive_mix(1'b1, 1'b1);
            return 1'b1;
        end
        if (req > REQ_PETAL)
            return 1'b0;
        case (req)
            REQ_FWD:    m_fwd = sp;
            REQ_STRAFE: m_strafe = sp;
            REQ_TURN:   m_turn = sp;
            default:    m_angle = petal_to_angle(sp);
        endcase
        m_idle = '0;
        m_fwd = squelch(m_fwd);
        m_strafe = squelch(m_strafe);
        m_turn = squelch(m_turn);
        res = drive_mix(1'b0, 1'b0);
        return 1'b1;
    endfunction

    function automatic logic signed [SPEED_W-1:0] pick_setpoint();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = int'(16'($urandom));
            2: v = int'($urandom_range(0, 255)) - 128;
            3:
            begin
                v = int'(m_deadband) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            4:
            begin
                case ($urandom_range(0, 7))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = Q_ONE;
                    3: v = -Q_ONE;
                    4: v = Q_ONE + 1;
                    5: v = -Q_ONE - 1;
                    6: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(0, 16383)) - 8192;
        endcase
        return 16'(v);
    endfunction

    task automatic push_item(input logic [REQ_W-1:0] req, input logic signed [SPEED_W-1:0] sp,
                             input bit typed, input drive_t want);
        drive_t res;
        bit got;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.req_type <= req;
        cmd.setpoint <= sp;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        got = mixer_step(req, sp, res);
        if (typed)
            expected_drive.push_back(want);
        else if (got)
            expected_drive.push_back(res);
    endtask

    // Stops sending, waits for every outstanding drive beat, then lets the pipeline empty.
    task automatic settle();
        cmd.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEADBAND)
            m_deadband = DB_W'(value);
        else
            m_wd_limit = TICK_W'(value);
    endtask

    task automatic random_items(input int count);
        int n;
        int r;
        int burst;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (m_wd_limit <= 64 && r < 8)
            begin
                // A run of ticks long enough to trip the watchdog now and then.
                burst = $urandom_range(1, int'(m_wd_limit) + 2);
                repeat (burst) push_item(REQ_TICK, 16'($urandom), 1'b0, '0);
                n += burst;
            end
            else if (r < 40)
            begin
                push_item(REQ_TICK, 16'($urandom), 1'b0, '0);
                n++;
            end
            else if (r < 90)
            begin
                push_item(3'($urandom_range(REQ_FWD, REQ_PETAL)), pick_setpoint(), 1'b0, '0);
                n++;
            end
            else
            begin
                push_item(3'($urandom_range(REQ_RSVD5, REQ_RSVD7)), 16'($urandom), 1'b0, '0);
                n++;
            end
        end
    endtask

    // Result side: random stall bursts while stall_pct is nonzero.
    always @(posedge clk)
    begin : ready_gen
        int stall_left;
        if (stall_left != 0)
        begin
            drv.ready <= 1'b0;
            stall_left--;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            drv.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            drv.ready <= 1'b1;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : drive_check
        drive_t want;
        if (rst_n && drv.valid && drv.ready)
        begin
            if (expected_drive.size() == 0)
            begin
                $error("drive beat arrived with nothing expected");
                fails++;
            end
            else
            begin
                want = expected_drive.pop_front();
                check_field("right_fwd_pwm", want.right_fwd, drv.right_fwd_pwm);
                check_field("right_rev_pwm", want.right_rev, drv.right_rev_pwm);
                check_field("back_fwd_pwm", want.back_fwd, drv.back_fwd_pwm);
                check_field("back_rev_pwm", want.back_rev, drv.back_rev_pwm);
                check_field("left_fwd_pwm", want.left_fwd, drv.left_fwd_pwm);
                check_field("left_rev_pwm", want.left_rev, drv.left_rev_pwm);
                check_field("servo_angle", want.servo, drv.servo_angle);
                check_field("timed_out", want.timed_out, drv.timed_out);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_omni_wheel_mixer_with_watchdog_core failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEADBAND;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.req_type = REQ_TICK;
        cmd.setpoint = '0;
        m_fwd = '0;
        m_strafe = '0;
        m_turn = '0;
        m_angle = 8'd103;
        m_idle = '0;
        m_deadband = 12'd41;
        m_wd_limit = 16'd7000;

        // Directed table at the reset deadband with a short watchdog limit: saturation,
        // deadband edges, petal clamping, unused codes, and the watchdog tripping.
        plan.push_back('{REQ_FWD, 16'sd0, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 103, 0}});
        plan.push_back('{REQ_FWD, 16'sd32767, 1, 1'b1, drive_t'{255, 0, 0, 0, 0, 255, 103, 0}});
        plan.push_back('{REQ_FWD, 16'sh8000, 1, 1'b1, drive_t'{0, 255, 0, 0, 255, 0, 103, 0}});
        plan.push_back('{REQ_FWD, 16'sd40, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 103, 0}});
        plan.push_back('{REQ_FWD, 16'sd41, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_FWD, 16'sd0, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 103, 0}});
        plan.push_back('{REQ_STRAFE, 16'sd32767, 1, 1'b1,
                         drive_t'{255, 0, 0, 255, 255, 0, 103, 0}});
        plan.push_back('{REQ_STRAFE, 16'sh8000, 1, 1'b1,
                         drive_t'{0, 255, 255, 0, 0, 255, 103, 0}});
        plan.push_back('{REQ_STRAFE, 16'sd0, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_TURN, 16'sd32767, 1, 1'b1, drive_t'{0, 255, 0, 255, 0, 255, 103, 0}});
        plan.push_back('{REQ_TURN, 16'sh8000, 1, 1'b1, drive_t'{255, 0, 255, 0, 255, 0, 103, 0}});
        plan.push_back('{REQ_TURN, -16'sd41, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_TURN, -16'sd40, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 103, 0}});
        plan.push_back('{REQ_PETAL, 16'sd32767, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 131, 0}});
        plan.push_back('{REQ_PETAL, 16'sh8000, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 94, 0}});
        plan.push_back('{REQ_PETAL, 16'sd0, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 112, 0}});
        plan.push_back('{REQ_PETAL, 16'sd4095, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_PETAL, -16'sd4097, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_RSVD5, 16'sd32767, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_RSVD6, -16'sd1, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_RSVD7, 16'sh8000, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_FWD, 16'sd12345, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_STRAFE, -16'sd2000, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_TURN, 16'sd700, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_PETAL, 16'sd0, 1, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_TICK, 16'sd0, DIRECTED_WD_LIMIT, 1'b0, drive_t'(0)});
        plan.push_back('{REQ_TICK, -16'sd1, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 112, 1}});
        plan.push_back('{REQ_PETAL, 16'sh8000, 1, 1'b1, drive_t'{0, 0, 0, 0, 0, 0, 94, 0}});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(CFG_WATCHDOG, DIRECTED_WD_LIMIT);
        gap_pct = 20;
        stall_pct = 20;
        foreach (plan[i])
            repeat (plan[i].reps) push_item(plan[i].req, plan[i].sp, plan[i].typed, plan[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cfg_write(CFG_DEADBAND, PH_DEADBAND[p]);
            cfg_write(CFG_WATCHDOG, PH_LIMIT[p]);
            gap_pct = PH_GAP[p];
            stall_pct = PH_STALL[p];
            random_items(ITEMS_PER_PHASE);
        end

        // Closing stretch at full rate on both sides.
        gap_pct = 0;
        stall_pct = 0;
        cfg_write(CFG_DEADBAND, 41);
        cfg_write(CFG_WATCHDOG, 20);
        random_items(ITEMS_PER_PHASE);

        settle();
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("tb_omni_wheel_mixer_with_watchdog_core passed");
        else
            $display("tb_omni_wheel_mixer_with_watchdog_core failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/owm_pkg.sv
src/owm_cmd_if.sv
src/owm_drv_if.sv
src/owm_front.sv
src/owm_queue.sv
src/owm_back.sv
src/omni_wheel_mixer_with_watchdog_core.sv
tb/tb_omni_wheel_mixer_with_watchdog_core.sv
